[rtl/tilt_complementary_filter_core_defines.svh]
// Assertion macros for the tilt complementary filter core.
`ifndef TILT_COMPLEMENTARY_FILTER_CORE_DEFINES_SVH
`define TILT_COMPLEMENTARY_FILTER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TCF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tcf assertion failed");
`define TCF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tcf assertion failed");
`else
`define TCF_ASSERT_IMPL(lbl, ante, cons)
`define TCF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/tcf_pkg.sv]
// Types and constants shared by the tilt complementary filter modules.
package tcf_pkg;

    localparam logic [29:0] NS_PER_S      = 30'd1000000000;
    localparam logic [28:0] NS_HALF       = 29'd500000000;
    localparam int          DIV_BITS      = 19;
    localparam int          RCP_IN_SHIFT  = 20;
    localparam int          RCP_OUT_SHIFT = 32;
    localparam logic [22:0] RCP_MULT      = 23'd4503600;
    localparam logic [15:0] WEIGHT_RESET  = 16'd655;
    localparam logic [31:0] ELAPSED_MAX   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic [62:0]        timestamp_ns;
    } t_imu_sample;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
    } t_tilt_result;

    typedef struct packed {
        logic start;
        logic take;
    } t_lane_cmd;

    typedef struct packed {
        logic done;
    } t_lane_stat;

endpackage

[rtl/tcf_lane.sv]
// One angle lane: gyro integration, iterative CORDIC atan2, divider and blend.
module tcf_lane #(
    parameter int CORDIC_STEPS = 14,
    parameter int ANGLE_BITS   = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  tcf_pkg::t_lane_cmd      i_cmd,
    input  logic signed [15:0]      i_gyro,
    input  logic signed [16:0]      i_acc_y,
    input  logic signed [16:0]      i_acc_x,
    input  logic [31:0]             i_elapsed,
    input  logic [15:0]             i_weight,
    output tcf_pkg::t_lane_stat     o_stat,
    output logic signed [15:0]      o_angle
);
    import tcf_pkg::*;

    localparam int F       = ANGLE_BITS - 4;
    localparam int ZW      = ANGLE_BITS + 1;
    localparam int XW      = 36;
    localparam int CW      = $clog2(CORDIC_STEPS + 1);
    localparam int IW      = $clog2(CORDIC_STEPS);

    typedef logic signed [ZW-1:0] t_atan_tab [CORDIC_STEPS];

    function automatic t_atan_tab build_atan();
        t_atan_tab tab;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            tab[i] = ZW'($rtoi($floor($atan(2.0 ** (-i)) * (2.0 ** F) + 0.5)));
        end
        return tab;
    endfunction

    localparam t_atan_tab ATAN = build_atan();

    typedef enum logic [5:0] {
        L_IDLE = 6'b000001,
        L_MUL  = 6'b000010,
        L_RUN  = 6'b000100,
        L_BLD  = 6'b001000,
        L_FIN  = 6'b010000,
        L_DONE = 6'b100000
    } t_lane_state;

    t_lane_state               r_st;
    logic signed [15:0]        r_angle;
    logic signed [15:0]        r_gyro;
    logic [31:0]               r_elapsed;
    logic signed [XW-1:0]      r_x, r_y;
    logic signed [ZW-1:0]      r_z;
    logic                      r_zero;
    logic [CW-1:0]             r_cnt;
    logic                      r_neg;
    logic [48:0]               r_dvd;
    logic [DIV_BITS-1:0]       r_qe;
    logic signed [49:0]        r_dif;
    logic [DIV_BITS-1:0]       r_quo;
    logic signed [38:0]        r_p1;
    logic signed [33:0]        r_p2;

    logic signed [XW-1:0]      n_x0, n_y0, w_xe, w_ye;
    logic signed [ZW-1:0]      n_z0;
    logic signed [48:0]        w_prod;
    logic [47:0]               w_pmag;
    logic [51:0]               w_rcp;
    logic [48:0]               w_qm;
    logic signed [XW-1:0]      w_xs, w_ys, n_x, n_y;
    logic signed [ZW-1:0]      n_z, w_atan;
    logic [IW-1:0]             w_idx;
    logic                      w_cordic_act;
    logic signed [20:0]        w_inc, w_gang;
    logic signed [ZW+12:0]     w_zx;
    logic signed [16:0]        w_acc, w_acc_conv;
    logic [16:0]               w_gw;
    logic signed [39:0]        w_num;
    logic [39:0]               w_nmag;
    logic [23:0]               w_q;
    logic signed [24:0]        w_res;
    logic signed [15:0]        w_sat;

    always_comb begin
        w_xe = XW'(i_acc_x) <<< 16;
        w_ye = XW'(i_acc_y) <<< 16;
        n_x0 = w_xe;
        n_y0 = w_ye;
        n_z0 = '0;
        if (w_xe < 0) begin
            if (w_ye >= 0) begin
                n_x0 = w_ye;
                n_y0 = -w_xe;
                n_z0 = ATAN[0] <<< 1;
            end else begin
                n_x0 = -w_ye;
                n_y0 = w_xe;
                n_z0 = -(ATAN[0] <<< 1);
            end
        end
    end

    assign w_prod = r_gyro * $signed({1'b0, r_elapsed});
    assign w_pmag = w_prod[48] ? 48'(-w_prod) : 48'(w_prod);

    assign w_rcp  = 52'(r_dvd[48:RCP_IN_SHIFT]) * 52'(RCP_MULT);
    assign w_qm   = 49'(r_qe) * 49'(NS_PER_S);

    assign w_cordic_act = (r_cnt < CW'(CORDIC_STEPS));
    assign w_idx        = w_cordic_act ? r_cnt[IW-1:0] : '0;
    assign w_atan       = ATAN[w_idx];
    assign w_xs         = r_x >>> r_cnt;
    assign w_ys         = r_y >>> r_cnt;

    always_comb begin
        if (!r_y[XW-1]) begin
            n_x = r_x + w_ys;
            n_y = r_y - w_xs;
            n_z = r_z + w_atan;
        end else begin
            n_x = r_x - w_ys;
            n_y = r_y + w_xs;
            n_z = r_z - w_atan;
        end
    end

    assign w_zx = (ZW+13)'(r_z);
    generate
        if (F > 12) begin : g_round
            localparam logic signed [ZW+12:0] RND = (ZW+13)'(1) <<< (F - 13);
            assign w_acc_conv = 17'((w_zx + RND) >>> (F - 12));
        end else begin : g_scale
            assign w_acc_conv = 17'(w_zx <<< (12 - F));
        end
    endgenerate

    assign w_acc  = r_zero ? 17'sd0 : w_acc_conv;
    assign w_inc  = r_neg ? -$signed({2'b00, r_quo}) : $signed({2'b00, r_quo});
    assign w_gang = 21'(r_angle) + w_inc;
    assign w_gw   = 17'h10000 - {1'b0, i_weight};

    assign w_num  = 40'(r_p1) + 40'(r_p2);
    assign w_nmag = w_num[39] ? 40'(-w_num) : 40'(w_num);
    assign w_q    = 24'((w_nmag + 40'd32768) >> 16);
    assign w_res  = w_num[39] ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q});

    always_comb begin
        if (w_res > 25'sd32767) begin
            w_sat = 16'sh7FFF;
        end else if (w_res < -25'sd32768) begin
            w_sat = -16'sh8000;
        end else begin
            w_sat = 16'(w_res);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= L_IDLE;
            r_angle <= '0;
        end else begin
            case (r_st)
                L_IDLE: begin
                    if (i_cmd.start) begin
                        r_gyro    <= i_gyro;
                        r_elapsed <= i_elapsed;
                        r_x       <= n_x0;
                        r_y       <= n_y0;
                        r_z       <= n_z0;
                        r_zero    <= (i_acc_x == 17'sd0) && (i_acc_y == 17'sd0);
                        r_st      <= L_MUL;
                    end
                end
                L_MUL: begin
                    r_neg <= w_prod[48];
                    r_dvd <= {w_pmag, 1'b0} + 49'(NS_HALF);
                    r_cnt <= '0;
                    r_st  <= L_RUN;
                end
                L_RUN: begin
                    if (w_cordic_act) begin
                        r_x <= n_x;
                        r_y <= n_y;
                        r_z <= n_z;
                    end
                    if (r_cnt == CW'(0)) begin
                        r_qe <= w_rcp[RCP_OUT_SHIFT +: DIV_BITS];
                    end
                    if (r_cnt == CW'(1)) begin
                        r_dif <= $signed({1'b0, r_dvd}) - $signed({1'b0, w_qm});
                    end
                    if (r_cnt == CW'(2)) begin
                        if (r_dif < 50'sd0) begin
                            r_quo <= r_qe - 1'b1;
                        end else if (r_dif >= $signed({20'd0, NS_PER_S})) begin
                            r_quo <= r_qe + 1'b1;
                        end else begin
                            r_quo <= r_qe;
                        end
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(CORDIC_STEPS - 1)) begin
                        r_st <= L_BLD;
                    end
                end
                L_BLD: begin
                    r_p1 <= $signed({1'b0, w_gw}) * w_gang;
                    r_p2 <= $signed({1'b0, i_weight}) * w_acc;
                    r_st <= L_FIN;
                end
                L_FIN: begin
                    r_angle <= w_sat;
                    r_st    <= L_DONE;
                end
                L_DONE: begin
                    if (i_cmd.take) begin
                        r_st <= L_IDLE;
                    end
                end
                default: r_st <= L_IDLE;
            endcase
        end
    end

    assign o_stat.done = (r_st == L_DONE);
    assign o_angle     = r_angle;

endmodule

[rtl/tcf_merge.sv]
// Result stage: joins the two lane angles into one output transaction.
module tcf_merge (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic signed [15:0]    i_roll,
    input  logic signed [15:0]    i_pitch,
    output logic                  o_can_load,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output tcf_pkg::t_tilt_result o_out_data
);
    import tcf_pkg::*;

    logic         r_valid;
    t_tilt_result r_data;

    assign o_can_load = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data.roll_angle  <= i_roll;
            r_data.pitch_angle <= i_pitch;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

[rtl/tilt_complementary_filter_core.sv]
// Tilt complementary filter core: roll and pitch from one IMU sample per transaction.
// A new sample is accepted only after the previous result has loaded into the output
// stage; the pace is set by the lane CORDIC loop, and the divide by 1e9 overlaps it.
// A stalled output holds the lanes and the input.
// Reset (synchronous, active low): angles, last time cleared, first-sample flag set,
// weight back to 655, output empty.
`include "tilt_complementary_filter_core_defines.svh"
module tilt_complementary_filter_core #(
    parameter int CORDIC_STEPS = 14,
    parameter int ANGLE_BITS   = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  tcf_pkg::t_imu_sample  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output tcf_pkg::t_tilt_result o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [15:0]           i_cfg_data
);
    import tcf_pkg::*;

    typedef enum logic [1:0] {
        T_IDLE = 2'b01,
        T_BUSY = 2'b10
    } t_top_state;

    t_top_state         r_tstate;
    logic [15:0]        r_weight;
    logic [62:0]        r_last_time;
    logic               r_first;

    logic               w_accept, w_load, w_can_load;
    logic [63:0]        w_diff;
    logic [31:0]        w_elapsed;
    t_lane_cmd          w_cmd;
    t_lane_stat         w_stat_roll, w_stat_pitch;
    logic signed [15:0] w_roll, w_pitch;
    logic signed [16:0] w_neg_ax;

    assign o_in_ready  = (r_tstate == T_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_load      = (r_tstate == T_BUSY) && w_stat_roll.done && w_stat_pitch.done
                         && w_can_load;

    assign w_diff = {1'b0, i_in_data.timestamp_ns} - {1'b0, r_last_time};

    always_comb begin
        if (r_first || (i_in_data.timestamp_ns < r_last_time)) begin
            w_elapsed = '0;
        end else if (w_diff > 64'(ELAPSED_MAX)) begin
            w_elapsed = ELAPSED_MAX;
        end else begin
            w_elapsed = w_diff[31:0];
        end
    end

    assign w_cmd.start = w_accept;
    assign w_cmd.take  = w_load;
    assign w_neg_ax    = -17'(i_in_data.accel_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tstate    <= T_IDLE;
            r_weight    <= WEIGHT_RESET;
            r_last_time <= '0;
            r_first     <= 1'b1;
        end else begin
            if (i_cfg_valid) begin
                r_weight <= i_cfg_data;
            end
            case (r_tstate)
                T_IDLE: begin
                    if (w_accept) begin
                        r_last_time <= i_in_data.timestamp_ns;
                        r_first     <= 1'b0;
                        r_tstate    <= T_BUSY;
                    end
                end
                T_BUSY: begin
                    if (w_load) begin
                        r_tstate <= T_IDLE;
                    end
                end
                default: r_tstate <= T_IDLE;
            endcase
        end
    end

    tcf_lane #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .ANGLE_BITS   (ANGLE_BITS)
    ) u_lane_roll (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_gyro    (i_in_data.gyro_x),
        .i_acc_y   (17'(i_in_data.accel_y)),
        .i_acc_x   (17'(i_in_data.accel_z)),
        .i_elapsed (w_elapsed),
        .i_weight  (r_weight),
        .o_stat    (w_stat_roll),
        .o_angle   (w_roll)
    );

    tcf_lane #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .ANGLE_BITS   (ANGLE_BITS)
    ) u_lane_pitch (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_gyro    (i_in_data.gyro_y),
        .i_acc_y   (w_neg_ax),
        .i_acc_x   (17'(i_in_data.accel_z)),
        .i_elapsed (w_elapsed),
        .i_weight  (r_weight),
        .o_stat    (w_stat_pitch),
        .o_angle   (w_pitch)
    );

    tcf_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_roll      (w_roll),
        .i_pitch     (w_pitch),
        .o_can_load  (w_can_load),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    `TCF_ASSERT_NEXT(a_accept_busy, w_accept, r_tstate == T_BUSY)
    `TCF_ASSERT_IMPL(a_lanes_lockstep, 1'b1, w_stat_roll.done == w_stat_pitch.done)
    `TCF_ASSERT_NEXT(a_load_valid, w_load, o_out_valid)
    `TCF_ASSERT_IMPL(a_idle_no_done, r_tstate == T_IDLE, !w_stat_roll.done)

endmodule

[tb/sv/tilt_complementary_filter_core_tb.sv]
// Testbench for the tilt complementary filter core: random IMU samples checked against a predictor.
`timescale 1ns / 100ps
module tilt_complementary_filter_core_tb;
    import tcf_pkg::*;

    localparam int STEPS = 14;
    localparam int FRAC = 12;
    localparam int LATENCY = 24;
    localparam longint LIMIT = 1200000;
    localparam logic [15:0] NO_CFG = 16'd0;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    class tilt_scoreboard;
        longint atan_tab[24];
        longint weight;
        longint roll_kept;
        longint pitch_kept;
        logic [62:0] prev_time;
        bit fresh;
        t_tilt_result pending[$];
        int mismatches;
        int checked;

        function new();
            int i;
            real a;
            for (i = 0; i < 24; i++) begin
                a = $atan(1.0 / (2.0 ** i)) * (2.0 ** FRAC);
                atan_tab[i] = longint'($floor(a + 0.5));
            end
            weight = 655;
            roll_kept = 0;
            pitch_kept = 0;
            prev_time = '0;
            fresh = 1'b1;
            mismatches = 0;
            checked = 0;
        endfunction

        function longint asr(longint v, int s);
            return v >>> s;
        endfunction

        function longint round_div(longint num, longint den);
            longint mag;
            longint q;
            mag = (num < 0) ? -num : num;
            q = (mag + den / 2) / den;
            return (num < 0) ? -q : q;
        endfunction

        function longint tilt_atan2(longint y, longint x);
            longint z;
            longint t;
            longint xs;
            longint ys;
            int i;
            z = 0;
            if (x == 0 && y == 0) return 0;
            x = x * 65536;
            y = y * 65536;
            if (x < 0) begin
                if (y >= 0) begin
                    t = x; x = y; y = -t; z = 2 * atan_tab[0];
                end else begin
                    t = x; x = -y; y = t; z = -2 * atan_tab[0];
                end
            end
            for (i = 0; i < STEPS; i++) begin
                xs = asr(x, i);
                ys = asr(y, i);
                if (y >= 0) begin
                    x += ys; y -= xs; z += atan_tab[i];
                end else begin
                    x -= ys; y += xs; z -= atan_tab[i];
                end
            end
            return z;
        endfunction

        function longint mix(longint gyro_ang, longint acc_ang);
            longint v;
            v = round_div((65536 - weight) * gyro_ang + weight * acc_ang, 65536);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v;
        endfunction

        function void note_sample(t_imu_sample s);
            longint roll_g;
            longint pitch_g;
            longint dt;
            t_tilt_result r;
            roll_g = roll_kept;
            pitch_g = pitch_kept;
            if (fresh) begin
                fresh = 1'b0;
            end else begin
                dt = (s.timestamp_ns >= prev_time) ? longint'(s.timestamp_ns - prev_time) : 0;
                if (dt > 64'hFFFF_FFFF) dt = 64'hFFFF_FFFF;
                roll_g += round_div(longint'(s.gyro_x) * dt * 2, 1000000000);
                pitch_g += round_div(longint'(s.gyro_y) * dt * 2, 1000000000);
            end
            prev_time = s.timestamp_ns;
            roll_kept = mix(roll_g, tilt_atan2(longint'(s.accel_y), longint'(s.accel_z)));
            pitch_kept = mix(pitch_g, tilt_atan2(-longint'(s.accel_x), longint'(s.accel_z)));
            r.roll_angle = roll_kept[15:0];
            r.pitch_angle = pitch_kept[15:0];
            pending.push_back(r);
        endfunction

        function void check_result(t_tilt_result got);
            t_tilt_result exp_r;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result roll=%0d pitch=%0d",
                                               got.roll_angle, got.pitch_angle);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch %0d: roll exp %0d got %0d, pitch exp %0d got %0d",
                             checked, exp_r.roll_angle, got.roll_angle,
                             exp_r.pitch_angle, got.pitch_angle);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_imu_sample i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_tilt_result o_out_data;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [15:0] i_cfg_data;

    tilt_scoreboard tilt_sb;
    t_idle_mode idle_mode;
    int hold_off;
    int sample_count;
    logic [62:0] clock_ns;
    longint cycles;

    tilt_complementary_filter_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = NO_CFG;
        idle_mode = IDLE_NONE;
        hold_off = 0;
        cycles = 0;
        tilt_sb = new();
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) tilt_sb.check_result(o_out_data);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_ready <= 1'b0;
        end else if (idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH) begin
            i_out_ready <= ($urandom_range(99) >= ((idle_mode == IDLE_RECV) ? 77 : 17));
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic send_sample(t_imu_sample s);
        int gap;
        if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) begin
            gap = 0;
            while ($urandom_range(99) < ((idle_mode == IDLE_SEND) ? 77 : 17)) gap++;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_data <= s;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        tilt_sb.note_sample(s);
        sample_count++;
    endtask

    task automatic write_weight(logic [15:0] w);
        i_cfg_data <= w;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        tilt_sb.weight = w;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (tilt_sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic t_imu_sample make_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                                                logic signed [15:0] az, logic signed [15:0] gx,
                                                logic signed [15:0] gy, logic [62:0] ts);
        t_imu_sample s;
        s.accel_x = ax; s.accel_y = ay; s.accel_z = az;
        s.gyro_x = gx; s.gyro_y = gy; s.timestamp_ns = ts;
        return s;
    endfunction

    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'(int'($urandom_range(600)) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_run(int count);
        logic [62:0] step;
        int i;
        for (i = 0; i < count; i++) begin
            case ($urandom_range(19))
                0: step = 63'({$urandom, $urandom});
                1: step = 63'h7FFF_FFFF_FFFF_FFFF;
                2: step = 63'h1_0000_0000 + 63'($urandom_range(8));
                3: step = 63'd0;
                default: step = 63'($urandom_range(20000000));
            endcase
            if ($urandom_range(29) == 0) clock_ns = clock_ns - 63'($urandom_range(5000000));
            else clock_ns = clock_ns + step;
            send_sample(make_sample(rand_axis(), rand_axis(), rand_axis(), rand_axis(),
                                    rand_axis(), clock_ns));
        end
    endtask

    logic [15:0] weights [6] = '{16'd655, 16'd0, 16'd65535, 16'd32768, 16'd6554, 16'd1};
    int k;

    initial begin
        sample_count = 0;
        clock_ns = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_sample(make_sample(16'sd100, 16'sd200, 16'sd16384, 16'sd2048, -16'sd2048,
                                63'd5000));
        send_sample(make_sample(16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000, 63'd10005000));
        send_sample(make_sample(16'sd0, 16'sd0, -16'sd100, 16'sh8000, 16'sh7FFF, 63'd10005000));
        send_sample(make_sample(16'sd50, 16'sd0, -16'sd100, 16'sd1, 16'sd1, 63'd1000));
        send_sample(make_sample(-16'sd50, -16'sd10, -16'sd100, -16'sd1, 16'sd0,
                                63'h7FFF_FFFF_FFFF_FFFF));
        send_sample(make_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sd5, 16'sd5,
                                63'h7FFF_FFFF_FFFF_FFFF));
        send_sample(make_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 63'd0));
        send_sample(make_sample(16'sd0, 16'sd300, 16'sd0, 16'sd0, 16'sd0, 63'hFFFF_FFFF));
        send_sample(make_sample(16'sd0, -16'sd300, 16'sd0, 16'sd0, 16'sd0, 63'h1_FFFF_FFFF));
        drain();

        for (k = 0; k < 6; k++) begin
            write_weight(weights[k]);
            idle_mode = t_idle_mode'(k % 4);
            clock_ns = 63'd1000;
            if (k == 2) begin
                hold_off = 400;
            end
            random_run(280);
            drain();
        end

        write_weight(16'($urandom));
        hold_off = 300;
        random_run(20);
        drain();

        $display("%0d IMU samples over 7 weight settings, %0d results, %0d mismatches",
                 sample_count, tilt_sb.checked, tilt_sb.mismatches);
        if (tilt_sb.mismatches == 0 && tilt_sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
